// File: rtl/min_fee_cap_shortest_path_defines.svh
// Assertion macros used by the top level of the fee-cap path block.
`ifndef MIN_FEE_CAP_SHORTEST_PATH_DEFINES_SVH
`define MIN_FEE_CAP_SHORTEST_PATH_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define MFC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition that must hold whenever the trigger holds.
`define MFC_ASSERT_IMPL(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

`endif

// File: rtl/mfc_pkg.sv
// Shared constants and types of the fee-cap path block.
`timescale 1ns / 1ps
package mfc_pkg;

   localparam int MAX_NODES_DEF = 1024;
   localparam int MAX_EDGES_DEF = 4096;
   localparam int DIST_BITS_DEF = 48;

   localparam int NODE_W   = 10;
   localparam int FEE_W    = 30;
   localparam int WEIGHT_W = 32;
   localparam int COUNT_W  = 11;
   localparam int BUDGET_W = 40;
   localparam int EDGE_W   = 2 * NODE_W + WEIGHT_W;

   localparam logic [FEE_W-1:0] CAP_END = 30'd1000000000;

   typedef enum logic [1:0] {
      OP_LOAD_FEE  = 2'd0,
      OP_LOAD_EDGE = 2'd1,
      OP_SOLVE     = 2'd2
   } mfc_op_type;

   localparam logic CSR_NODE_COUNT = 1'b0;
   localparam logic CSR_BUDGET     = 1'b1;

   typedef enum logic [1:0] {
      UNIT_MIN   = 2'b01,
      UNIT_RELAX = 2'b10
   } mfc_unit_op_type;

   typedef struct packed {
      mfc_unit_op_type op;
      logic            settled;
   } mfc_unit_ctl_type;

endpackage

// File: rtl/mfc_ram.sv
// Generic single-write, single-read memory with a registered read port.
`timescale 1ns / 1ps
module mfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mfc_dist_unit.sv
// Shared distance unit: saturating add and one less-than compare.
`timescale 1ns / 1ps
module mfc_dist_unit #(
   parameter int DIST_BITS = mfc_pkg::DIST_BITS_DEF
) (
   input  mfc_pkg::mfc_unit_ctl_type ctl,
   input  logic [DIST_BITS-1:0]      base,
   input  logic [DIST_BITS-1:0]      entry,
   input  logic [mfc_pkg::WEIGHT_W-1:0] weight,
   output logic [DIST_BITS-1:0]      value,
   output logic                      take
);
   import mfc_pkg::*;

   localparam logic [DIST_BITS-1:0] DIST_INF = {DIST_BITS{1'b1}};

   logic [DIST_BITS:0]   sum;
   logic [DIST_BITS-1:0] sat;
   logic [DIST_BITS-1:0] cand;
   logic [DIST_BITS-1:0] limit;

   always_comb begin
      sum = {1'b0, base} + (DIST_BITS + 1)'(weight);
      // A carry out means the path sum passed the largest distance.
      sat = sum[DIST_BITS] ? DIST_INF : sum[DIST_BITS-1:0];
      case (ctl.op)
         UNIT_RELAX: begin
            cand  = sat;
            limit = entry;
         end
         default: begin
            cand  = entry;
            limit = base;
         end
      endcase
      value = cand;
      take  = !ctl.settled && (cand < limit);
   end

endmodule

// File: rtl/min_fee_cap_shortest_path.sv
// Top level of the fee-cap path block: loads, search sequencer and memories.
//
// The block stores one fee per node and a list of undirected weighted edges, and on a
// solve request it binary-searches the smallest fee cap in [0, 1e9) for which the
// shortest path from node 0 to node node_count-1, using only edges whose two ends both
// have fee at most the cap, costs no more than budget. Fee and edge loads give no
// response; a solve gives one response carrying the cap, or the cap 1e9 with the
// unreachable flag set. A solve runs at most 30 trials, one per halving of the search
// range. Each trial first resets the distance memory, then runs up to n rounds of a
// selection pass (one distance read and compare per node) and an edge pass (a read of
// every loaded edge, with fee checks and a relaxation for each edge that touches the
// chosen node), with n the node count in use. A trial ends early once the target node
// is chosen. The work is bound by the single read port of the distance memory and one
// shared add-compare unit. The block stalls new requests while a solve is running; a
// finished response waits in an output register so loads can be taken while it is
// pending.
`timescale 1ns / 1ps
module min_fee_cap_shortest_path #(
   parameter int MAX_NODES = mfc_pkg::MAX_NODES_DEF,
   parameter int MAX_EDGES = mfc_pkg::MAX_EDGES_DEF,
   parameter int DIST_BITS = mfc_pkg::DIST_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_operation,
   input  logic [mfc_pkg::NODE_W-1:0]    req_node,
   input  logic [mfc_pkg::NODE_W-1:0]    req_other_node,
   input  logic [mfc_pkg::FEE_W-1:0]     req_fee,
   input  logic [mfc_pkg::WEIGHT_W-1:0]  req_weight,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mfc_pkg::FEE_W-1:0]     rsp_min_fee_cap,
   output logic                          rsp_unreachable,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [mfc_pkg::BUDGET_W-1:0]  csr_data
);
   import mfc_pkg::*;

`include "min_fee_cap_shortest_path_defines.svh"

   localparam int NODE_AW = $clog2(MAX_NODES);
   localparam int LIVE_RAW = $clog2(MAX_NODES + 1);
   localparam int LIVE_W = (LIVE_RAW > COUNT_W) ? LIVE_RAW : COUNT_W;
   localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ETOT_W = $clog2(MAX_EDGES + 1);
   localparam int CMP_W = (DIST_BITS > BUDGET_W) ? DIST_BITS : BUDGET_W;
   localparam logic [DIST_BITS-1:0] DIST_INF = {DIST_BITS{1'b1}};

   typedef enum logic [12:0] {
      ST_IDLE     = 13'b0000000000001,
      ST_TRIAL    = 13'b0000000000010,
      ST_INIT     = 13'b0000000000100,
      ST_SCAN_RD  = 13'b0000000001000,
      ST_SCAN_CMP = 13'b0000000010000,
      ST_PICK     = 13'b0000000100000,
      ST_EDGE_RD  = 13'b0000001000000,
      ST_EDGE_CHK = 13'b0000010000000,
      ST_FEE_A    = 13'b0000100000000,
      ST_FEE_B    = 13'b0001000000000,
      ST_RELAX    = 13'b0010000000000,
      ST_FINISH   = 13'b0100000000000,
      ST_DONE     = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [COUNT_W-1:0]  node_count_ff, node_count_in;
   logic [BUDGET_W-1:0] budget_ff, budget_in;
   logic [ETOT_W-1:0]   edge_total_ff, edge_total_in;
   logic [FEE_W-1:0]    low_ff, low_in;
   logic [FEE_W-1:0]    high_ff, high_in;
   logic [FEE_W-1:0]    cap_ff, cap_in;
   logic [LIVE_W-1:0]   idx_ff, idx_in;
   logic [DIST_BITS-1:0] bd_ff, bd_in;
   logic [NODE_AW-1:0]  best_ff, best_in;
   logic                best_valid_ff, best_valid_in;
   logic [ETOT_W-1:0]   k_ff, k_in;
   logic [NODE_AW-1:0]  other_ff, other_in;
   logic                ok_ff, ok_in;
   logic                feasible_ff, feasible_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FEE_W-1:0]    rsp_cap_ff, rsp_cap_in;
   logic                rsp_unreach_ff, rsp_unreach_in;

   // Memory ports.
   logic                 fee_wr_en, fee_rd_en;
   logic [NODE_AW-1:0]   fee_wr_addr, fee_rd_addr;
   logic [FEE_W-1:0]     fee_rd_data;
   logic                 edge_wr_en, edge_rd_en;
   logic [EDGE_W-1:0]    edge_wr_data, edge_rd_data;
   logic                 dist_wr_en, dist_rd_en;
   logic [NODE_AW-1:0]   dist_wr_addr, dist_rd_addr;
   logic [DIST_BITS:0]   dist_wr_data, dist_rd_data;

   // Shared unit.
   mfc_unit_ctl_type     unit_ctl;
   logic [DIST_BITS-1:0] unit_value;
   logic                 unit_take;

   logic                 req_take;
   logic [LIVE_W-1:0]    nc_ext, live_n, target;
   logic [FEE_W:0]       mid_sum;
   logic [NODE_W-1:0]    e_a, e_b;
   logic [WEIGHT_W-1:0]  e_w;
   logic                 a_in, b_in, a_is, b_is;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_min_fee_cap = rsp_cap_ff;
   assign rsp_unreachable = rsp_unreach_ff;

   // Node count in use: zero counts as one, large values saturate at capacity.
   assign nc_ext = LIVE_W'(node_count_ff);
   assign live_n = (nc_ext == '0) ? LIVE_W'(1) :
                   (nc_ext > LIVE_W'(MAX_NODES)) ? LIVE_W'(MAX_NODES) : nc_ext;
   assign target = live_n - LIVE_W'(1);

   assign mid_sum = {1'b0, low_ff} + {1'b0, high_ff};

   assign e_a = edge_rd_data[EDGE_W-1 -: NODE_W];
   assign e_b = edge_rd_data[WEIGHT_W +: NODE_W];
   assign e_w = edge_rd_data[WEIGHT_W-1:0];

   assign a_in = LIVE_W'(e_a) < live_n;
   assign b_in = LIVE_W'(e_b) < live_n;
   assign a_is = LIVE_W'(e_a) == LIVE_W'(best_ff);
   assign b_is = LIVE_W'(e_b) == LIVE_W'(best_ff);

   // Fee loads and edge loads go straight into their memories; edges past a full table are dropped.
   assign fee_wr_en   = req_take && (req_operation == OP_LOAD_FEE) &&
                        (LIVE_W'(req_node) < LIVE_W'(MAX_NODES));
   assign fee_wr_addr = NODE_AW'(req_node);
   assign edge_wr_en  = req_take && (req_operation == OP_LOAD_EDGE) &&
                        (edge_total_ff < ETOT_W'(MAX_EDGES));
   assign edge_wr_data = {req_node, req_other_node, req_weight};

   assign fee_rd_en   = (state_ff == ST_EDGE_CHK) || (state_ff == ST_FEE_A);
   assign fee_rd_addr = (state_ff == ST_FEE_A) ? NODE_AW'(e_b) : NODE_AW'(e_a);
   assign edge_rd_en  = (state_ff == ST_EDGE_RD);
   assign dist_rd_en  = (state_ff == ST_SCAN_RD) || (state_ff == ST_FEE_B);
   assign dist_rd_addr = (state_ff == ST_FEE_B) ? other_ff : NODE_AW'(idx_ff);

   assign unit_ctl.op      = (state_ff == ST_RELAX) ? UNIT_RELAX : UNIT_MIN;
   assign unit_ctl.settled = dist_rd_data[DIST_BITS];

   always_comb begin
      state_in       = state_ff;
      node_count_in  = node_count_ff;
      budget_in      = budget_ff;
      edge_total_in  = edge_total_ff;
      low_in         = low_ff;
      high_in        = high_ff;
      cap_in         = cap_ff;
      idx_in         = idx_ff;
      bd_in          = bd_ff;
      best_in        = best_ff;
      best_valid_in  = best_valid_ff;
      k_in           = k_ff;
      other_in       = other_ff;
      ok_in          = ok_ff;
      feasible_in    = feasible_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_cap_in     = rsp_cap_ff;
      rsp_unreach_in = rsp_unreach_ff;
      dist_wr_en     = 1'b0;
      dist_wr_addr   = NODE_AW'(idx_ff);
      dist_wr_data   = {1'b0, DIST_INF};

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NODE_COUNT: node_count_in = csr_data[COUNT_W-1:0];
            CSR_BUDGET:     budget_in     = csr_data;
            default: ;
         endcase
      end

      if (edge_wr_en) begin
         edge_total_in = edge_total_ff + ETOT_W'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_operation == OP_SOLVE)) begin
               low_in   = '0;
               high_in  = CAP_END;
               state_in = ST_TRIAL;
            end
         end
         ST_TRIAL: begin
            if (low_ff >= high_ff) begin
               state_in = ST_DONE;
            end else begin
               cap_in   = mid_sum[FEE_W:1];
               idx_in   = '0;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            // Source starts at zero, every other node at infinity, none settled.
            dist_wr_en   = 1'b1;
            dist_wr_data = {1'b0, (idx_ff == '0) ? '0 : DIST_INF};
            if (idx_ff == target) begin
               idx_in        = '0;
               bd_in         = DIST_INF;
               best_valid_in = 1'b0;
               state_in      = ST_SCAN_RD;
            end else begin
               idx_in = idx_ff + LIVE_W'(1);
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            // Lowest index wins a tie, since only a strictly smaller distance replaces.
            if (unit_take) begin
               bd_in         = unit_value;
               best_in       = NODE_AW'(idx_ff);
               best_valid_in = 1'b1;
            end
            if (idx_ff == target) begin
               state_in = ST_PICK;
            end else begin
               idx_in   = idx_ff + LIVE_W'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_PICK: begin
            if (!best_valid_ff) begin
               feasible_in = 1'b0;
               state_in    = ST_FINISH;
            end else if (LIVE_W'(best_ff) == target) begin
               feasible_in = CMP_W'(bd_ff) <= CMP_W'(budget_ff);
               state_in    = ST_FINISH;
            end else begin
               dist_wr_en   = 1'b1;
               dist_wr_addr = best_ff;
               dist_wr_data = {1'b1, bd_ff};
               k_in         = '0;
               state_in     = ST_EDGE_RD;
            end
         end
         ST_EDGE_RD: begin
            if (k_ff == edge_total_ff) begin
               idx_in        = '0;
               bd_in         = DIST_INF;
               best_valid_in = 1'b0;
               state_in      = ST_SCAN_RD;
            end else begin
               state_in = ST_EDGE_CHK;
            end
         end
         ST_EDGE_CHK: begin
            if (a_in && b_in && (a_is || b_is)) begin
               other_in = a_is ? NODE_AW'(e_b) : NODE_AW'(e_a);
               state_in = ST_FEE_A;
            end else begin
               k_in     = k_ff + ETOT_W'(1);
               state_in = ST_EDGE_RD;
            end
         end
         ST_FEE_A: begin
            ok_in    = fee_rd_data <= cap_ff;
            state_in = ST_FEE_B;
         end
         ST_FEE_B: begin
            if (ok_ff && (fee_rd_data <= cap_ff)) begin
               state_in = ST_RELAX;
            end else begin
               k_in     = k_ff + ETOT_W'(1);
               state_in = ST_EDGE_RD;
            end
         end
         ST_RELAX: begin
            if (unit_take) begin
               dist_wr_en   = 1'b1;
               dist_wr_addr = other_ff;
               dist_wr_data = {1'b0, unit_value};
            end
            k_in     = k_ff + ETOT_W'(1);
            state_in = ST_EDGE_RD;
         end
         ST_FINISH: begin
            if (feasible_ff) begin
               high_in = cap_ff;
            end else begin
               low_in = cap_ff + FEE_W'(1);
            end
            state_in = ST_TRIAL;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_cap_in     = low_ff;
               rsp_unreach_in = (low_ff == CAP_END);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= COUNT_W'(1);
         budget_ff     <= '0;
         edge_total_ff <= '0;
         low_ff        <= '0;
         high_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         budget_ff     <= budget_in;
         edge_total_ff <= edge_total_in;
         low_ff        <= low_in;
         high_ff       <= high_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff         <= cap_in;
      idx_ff         <= idx_in;
      bd_ff          <= bd_in;
      best_ff        <= best_in;
      best_valid_ff  <= best_valid_in;
      k_ff           <= k_in;
      other_ff       <= other_in;
      ok_ff          <= ok_in;
      feasible_ff    <= feasible_in;
      rsp_cap_ff     <= rsp_cap_in;
      rsp_unreach_ff <= rsp_unreach_in;
   end

   mfc_ram #(.WIDTH(FEE_W), .DEPTH(MAX_NODES)) u_fee_ram (
      .clock   (clock),
      .wr_en   (fee_wr_en),
      .wr_addr (fee_wr_addr),
      .wr_data (req_fee),
      .rd_en   (fee_rd_en),
      .rd_addr (fee_rd_addr),
      .rd_data (fee_rd_data)
   );

   mfc_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr_en),
      .wr_addr (EDGE_AW'(edge_total_ff)),
      .wr_data (edge_wr_data),
      .rd_en   (edge_rd_en),
      .rd_addr (EDGE_AW'(k_ff)),
      .rd_data (edge_rd_data)
   );

   // Each entry holds a settled flag above the tentative distance.
   mfc_ram #(.WIDTH(DIST_BITS + 1), .DEPTH(MAX_NODES)) u_dist_ram (
      .clock   (clock),
      .wr_en   (dist_wr_en),
      .wr_addr (dist_wr_addr),
      .wr_data (dist_wr_data),
      .rd_en   (dist_rd_en),
      .rd_addr (dist_rd_addr),
      .rd_data (dist_rd_data)
   );

   mfc_dist_unit #(.DIST_BITS(DIST_BITS)) u_dist_unit (
      .ctl    (unit_ctl),
      .base   (bd_ff),
      .entry  (dist_rd_data[DIST_BITS-1:0]),
      .weight (e_w),
      .value  (unit_value),
      .take   (unit_take)
   );

   // The search range never inverts and never leaves [0, 1e9].
   `MFC_ASSERT_ALWAYS(a_search_range, (low_ff <= high_ff) && (high_ff <= CAP_END), "search range broken")

   // The unreachable flag goes with the end-of-range cap and only with it.
   `MFC_ASSERT_IMPL(a_unreach_cap, rsp_valid_ff, rsp_unreach_ff == (rsp_cap_ff == CAP_END), "unreachable flag mismatch")

   // A chosen node always lies inside the nodes in use.
   `MFC_ASSERT_IMPL(a_best_in_range, (state_ff == ST_PICK) && best_valid_ff, LIVE_W'(best_ff) < live_n, "chosen node out of range")

endmodule
